FILE: sv/afa_pkg.sv
// Package for the array factor accumulator: sequencer states, field widths,
// register indexes and fixed-point constants. No dependencies.
package afa_pkg;

    localparam int COORD_W   = 8;
    localparam int CURRENT_W = 16;
    localparam int STEP_W    = 32;
    localparam int FACTOR_W  = 48;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 8'd1;

    // pi/2 in Q30 and unity in Q30, used when the trig ROM is built
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    localparam logic signed [FACTOR_W-1:0] ACC_MAX = {1'b0, {(FACTOR_W-1){1'b1}}};
    localparam logic signed [FACTOR_W-1:0] ACC_MIN = {1'b1, {(FACTOR_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PX,
        ST_PY,
        ST_SUM,
        ST_IDX,
        ST_ROM,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_ACC,
        ST_FIN
    } afa_state_t;

endpackage

FILE: sv/array_factor_accumulator.sv
// Array factor accumulator: per-element phase, cos/sin ROM lookup, complex
// rotation and saturating accumulation over one shared 33x18 multiplier.
// Depends on afa_pkg.
//
// Sequence: an accepted element walks PX, PY, SUM, IDX, ROM, M0, M1, M2, M3, ACC and
// FIN, and m_valid rises as FIN closes a last element; a closing element waits in FIN
// while a stalled result beat is not yet taken.
// The walk is seven passes of the shared multiplier plus the ROM read, the phase sum,
// the imaginary sum, the closing step and the accept in IDLE; a new element is taken
// only back in IDLE, once the previous one has finished.
// Reset: aresetn (synchronous, active low) clears the phase steps, the sums,
// the sequencer and the output valid; the trig ROM is constant.
module array_factor_accumulator #(
    parameter int TRIG_ENTRIES = 4096
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [afa_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [afa_pkg::STEP_W-1:0]             cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [afa_pkg::COORD_W-1:0]            s_grid_col,
    input  logic [afa_pkg::COORD_W-1:0]            s_grid_row,
    input  logic signed [afa_pkg::CURRENT_W-1:0]   s_current_re,
    input  logic signed [afa_pkg::CURRENT_W-1:0]   s_current_im,
    input  logic                                   s_last_element,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [afa_pkg::FACTOR_W-1:0]    m_factor_re,
    output logic signed [afa_pkg::FACTOR_W-1:0]    m_factor_im
);
    import afa_pkg::*;

    localparam int ENTRY_W = $clog2(TRIG_ENTRIES);

    typedef logic [2*CURRENT_W-1:0] rom_t [TRIG_ENTRIES];

    function automatic logic [CURRENT_W-1:0] q30_to_q15(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        logic [63:0] neg_r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r   = (mag + 64'd16384) >> 15;
        if (v < 0) begin
            if (r > 64'd32768) r = 64'd32768;
            neg_r = -r;
            return neg_r[CURRENT_W-1:0];
        end
        if (r > 64'd32767) r = 64'd32767;
        return r[CURRENT_W-1:0];
    endfunction

    // Taylor series in Q30 per entry, quadrant fold, then round to Q15
    function automatic rom_t build_rom();
        rom_t                rom;
        logic [63:0]         turn;
        logic [63:0]         rem;
        logic [63:0]         x;
        logic [63:0]         x2;
        logic [63:0]         tc;
        logic [63:0]         ts;
        logic signed [63:0]  c;
        logic signed [63:0]  s;
        logic signed [63:0]  oc;
        logic signed [63:0]  os;
        logic [1:0]          quad;
        for (int i = 0; i < TRIG_ENTRIES; i++) begin
            turn = (64'(i) << 32) / 64'(TRIG_ENTRIES);
            quad = turn[31:30];
            rem  = turn & 64'h3FFF_FFFF;
            x    = (rem * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            tc   = ONE_Q30;
            ts   = x;
            c    = signed'(ONE_Q30);
            s    = signed'(x);
            for (int n = 1; n <= 10; n++) begin
                tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    c = c - signed'(tc);
                    s = s - signed'(ts);
                end else begin
                    c = c + signed'(tc);
                    s = s + signed'(ts);
                end
            end
            case (quad)
                2'd0:    begin oc = c;  os = s;  end
                2'd1:    begin oc = -s; os = c;  end
                2'd2:    begin oc = -c; os = -s; end
                default: begin oc = s;  os = -c; end
            endcase
            rom[i] = {q30_to_q15(oc), q30_to_q15(os)};
        end
        return rom;
    endfunction

    localparam rom_t TRIG_ROM = build_rom();

    function automatic logic signed [FACTOR_W-1:0] sat_sum(
        input logic signed [FACTOR_W-1:0] acc,
        input logic signed [33:0]         term
    );
        logic signed [FACTOR_W+1:0] wide;
        wide = {{2{acc[FACTOR_W-1]}}, acc} + {{(FACTOR_W-32){term[33]}}, term};
        if (wide > signed'({{2{ACC_MAX[FACTOR_W-1]}}, ACC_MAX})) return ACC_MAX;
        if (wide < signed'({{2{ACC_MIN[FACTOR_W-1]}}, ACC_MIN})) return ACC_MIN;
        return wide[FACTOR_W-1:0];
    endfunction

    afa_state_t                     state_reg, state_next;

    logic [STEP_W-1:0]              step_x_reg, step_y_reg;
    logic [COORD_W-1:0]             col_reg, row_reg;
    logic signed [CURRENT_W-1:0]    cr_reg, ci_reg;
    logic                           last_reg;

    logic [STEP_W-1:0]              phase_reg;
    logic [2*CURRENT_W-1:0]         trig_reg;
    logic signed [50:0]             prod_reg;
    logic signed [33:0]             t_re_reg, t_im_reg;
    logic signed [FACTOR_W-1:0]     acc_re_reg, acc_im_reg;

    logic                           m_valid_reg;
    logic signed [FACTOR_W-1:0]     out_re_reg, out_im_reg;

    logic signed [32:0]             mul_a;
    logic signed [17:0]             mul_b;
    logic signed [50:0]             mul_p;
    logic signed [CURRENT_W-1:0]    cos_q15, sin_q15;
    logic signed [33:0]             prod_lo;
    logic                           fin_go;
    logic                           accept;

    assign cos_q15 = trig_reg[2*CURRENT_W-1:CURRENT_W];
    assign sin_q15 = trig_reg[CURRENT_W-1:0];
    assign prod_lo = {{2{prod_reg[31]}}, prod_reg[31:0]};
    assign accept  = s_valid && s_ready;
    // a closing element waits until the previous result beat has gone
    assign fin_go  = !last_reg || !m_valid_reg || m_ready;

    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_factor_re = out_re_reg;
    assign m_factor_im = out_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = ST_PX;
            end
            ST_PX: begin
                mul_a      = {1'b0, step_x_reg};
                mul_b      = {10'b0, col_reg};
                state_next = ST_PY;
            end
            ST_PY: begin
                mul_a      = {1'b0, step_y_reg};
                mul_b      = {10'b0, row_reg};
                state_next = ST_SUM;
            end
            ST_SUM: state_next = ST_IDX;
            ST_IDX: begin
                mul_a      = {1'b0, phase_reg};
                mul_b      = 18'(TRIG_ENTRIES);
                state_next = ST_ROM;
            end
            ST_ROM: state_next = ST_M0;
            ST_M0: begin
                mul_a      = {{17{cr_reg[CURRENT_W-1]}}, cr_reg};
                mul_b      = {{2{cos_q15[CURRENT_W-1]}}, cos_q15};
                state_next = ST_M1;
            end
            ST_M1: begin
                mul_a      = {{17{ci_reg[CURRENT_W-1]}}, ci_reg};
                mul_b      = {{2{sin_q15[CURRENT_W-1]}}, sin_q15};
                state_next = ST_M2;
            end
            ST_M2: begin
                mul_a      = {{17{cr_reg[CURRENT_W-1]}}, cr_reg};
                mul_b      = {{2{sin_q15[CURRENT_W-1]}}, sin_q15};
                state_next = ST_M3;
            end
            ST_M3: begin
                mul_a      = {{17{ci_reg[CURRENT_W-1]}}, ci_reg};
                mul_b      = {{2{cos_q15[CURRENT_W-1]}}, cos_q15};
                state_next = ST_ACC;
            end
            ST_ACC: state_next = ST_FIN;
            ST_FIN: begin
                if (fin_go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // datapath without reset
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (accept) begin
            col_reg  <= s_grid_col;
            row_reg  <= s_grid_row;
            cr_reg   <= s_current_re;
            ci_reg   <= s_current_im;
            last_reg <= s_last_element;
        end
        case (state_reg)
            ST_PY:  phase_reg <= prod_reg[STEP_W-1:0];
            ST_SUM: phase_reg <= phase_reg + prod_reg[STEP_W-1:0];
            ST_ROM: trig_reg  <= TRIG_ROM[prod_reg[STEP_W +: ENTRY_W]];
            ST_M1:  t_re_reg  <= prod_lo;
            ST_M2:  t_re_reg  <= t_re_reg - prod_lo;
            ST_M3:  t_im_reg  <= prod_lo;
            ST_ACC: t_im_reg  <= t_im_reg + prod_lo;
            default: ;
        endcase
        if (state_reg == ST_FIN && fin_go && last_reg) begin
            out_re_reg <= acc_re_reg;
            out_im_reg <= sat_sum(acc_im_reg, t_im_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            acc_re_reg  <= '0;
            acc_im_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_STEP_X: step_x_reg <= cfg_data;
                    REG_STEP_Y: step_y_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_M3) acc_re_reg <= sat_sum(acc_re_reg, t_re_reg);
            if (state_reg == ST_FIN && fin_go) begin
                if (last_reg) begin
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                end else begin
                    acc_im_reg <= sat_sum(acc_im_reg, t_im_reg);
                end
            end
            if (state_reg == ST_FIN && fin_go && last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/afa_checker.sv
// Port-level checker for array_factor_accumulator and its bind.
// Depends on afa_pkg for field widths.
module afa_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 cfg_ready,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [afa_pkg::FACTOR_W-1:0]  m_factor_re,
    input logic signed [afa_pkg::FACTOR_W-1:0]  m_factor_im
);
    import afa_pkg::*;

    // after taking an element, the sequencer holds input ready low while it is busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready ##1 !s_ready)
        else $error("input ready while an element is still in work");

    // no result can appear the cycle after an element beat
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result beat too soon after an element beat");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_factor_re) && $stable(m_factor_im))
        else $error("stalled result beat changed");

    a_cfg_always_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind array_factor_accumulator afa_checker u_afa_checker (.*);

FILE: test/tb_top.sv
// Testbench for array_factor_accumulator: drives element beats and phase-step writes,
// predicts every summed array factor in place and checks it against the result channel.
// Depends on afa_pkg and the array_factor_accumulator RTL.
module tb_top;
    import afa_pkg::*;

    localparam int TRIG_SIZE    = 4096;
    localparam int LIMIT_CYCLES = 100000;
    localparam int SETTLE       = 16;    // long enough for an element in work to retire
    localparam int HOLD_CYCLES  = 600;
    localparam int LONG_SUM     = 100;   // one sum far longer than the random ones
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint FACTOR_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint FACTOR_LO = -64'sh0000_8000_0000_0000;
    // register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

    typedef struct packed {
        logic signed [FACTOR_W-1:0] re;
        logic signed [FACTOR_W-1:0] im;
    } factor_t;

    logic                        aclk           = 1'b0;
    logic                        aresetn        = 1'b0;
    logic                        cfg_valid      = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index      = '0;
    logic [STEP_W-1:0]           cfg_data       = '0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic [COORD_W-1:0]          s_grid_col     = '0;
    logic [COORD_W-1:0]          s_grid_row     = '0;
    logic signed [CURRENT_W-1:0] s_current_re   = '0;
    logic signed [CURRENT_W-1:0] s_current_im   = '0;
    logic                        s_last_element = 1'b0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic signed [FACTOR_W-1:0]  m_factor_re;
    logic signed [FACTOR_W-1:0]  m_factor_im;

    // predictor state
    logic signed [CURRENT_W-1:0] cos_rom [TRIG_SIZE];
    logic signed [CURRENT_W-1:0] sin_rom [TRIG_SIZE];
    logic [STEP_W-1:0]           step_x  = '0;
    logic [STEP_W-1:0]           step_y  = '0;
    longint                      sum_re  = 0;
    longint                      sum_im  = 0;
    factor_t                     pending_factors [$];

    bit calm     = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;
    int hold_left       = 0;
    int mismatches      = 0;
    int elements_sent   = 0;
    int factors_checked = 0;
    int step_writes     = 0;
    int cycle_count     = 0;

    array_factor_accumulator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_grid_col     (s_grid_col),
        .s_grid_row     (s_grid_row),
        .s_current_re   (s_current_re),
        .s_current_im   (s_current_im),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_factor_re    (m_factor_re),
        .m_factor_im    (m_factor_im)
    );

    always #10 aclk = ~aclk;

    function automatic logic signed [CURRENT_W-1:0] round_to_q15(input longint v);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? -v : v;
        r = (mag + 64'd16384) >> 15;
        if (v < 0) begin
            if (r > 64'd32768) r = 64'd32768;
            return CURRENT_W'(-r);
        end
        if (r > 64'd32767) r = 64'd32767;
        return CURRENT_W'(r);
    endfunction

    // Q30 Taylor series on the remainder angle, then fold by quadrant
    function automatic void build_trig_rom();
        longint unsigned turn, quad, rem, x, x2, tc, ts;
        longint c, s, oc, os;
        for (int i = 0; i < TRIG_SIZE; i++) begin
            turn = 64'(i);
            turn = (turn << 32) / TRIG_SIZE;
            quad = (turn >> 30) & 64'd3;
            rem  = turn & ((64'd1 << 30) - 64'd1);
            x    = (rem * PI_HALF_Q30) >> 30;
            x2   = (x * x) >> 30;
            tc   = 64'd1 << 30;
            ts   = x;
            c    = 64'sd1 << 30;
            s    = longint'(x);
            for (longint unsigned n = 1; n <= 10; n++) begin
                tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
                ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    c = c - longint'(tc);
                    s = s - longint'(ts);
                end else begin
                    c = c + longint'(tc);
                    s = s + longint'(ts);
                end
            end
            case (quad)
                0: begin oc = c;  os = s;  end
                1: begin oc = -s; os = c;  end
                2: begin oc = -c; os = -s; end
                default: begin oc = s; os = -c; end
            endcase
            cos_rom[i] = round_to_q15(oc);
            sin_rom[i] = round_to_q15(os);
        end
    endfunction

    function automatic longint clamp_factor(input longint v);
        if (v > FACTOR_HI) return FACTOR_HI;
        if (v < FACTOR_LO) return FACTOR_LO;
        return v;
    endfunction

    function automatic void rotate_and_accumulate(input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] row,
                                                  input logic signed [CURRENT_W-1:0] cr,
                                                  input logic signed [CURRENT_W-1:0] ci,
                                                  input bit last);
        logic [STEP_W-1:0] phase;
        logic [11:0]       idx;
        longint            c, s;
        factor_t           f;
        phase = col * step_x + row * step_y;
        idx   = phase[STEP_W-1 -: 12];
        c     = cos_rom[idx];
        s     = sin_rom[idx];
        sum_re = clamp_factor(sum_re + longint'(cr) * c - longint'(ci) * s);
        sum_im = clamp_factor(sum_im + longint'(cr) * s + longint'(ci) * c);
        if (last) begin
            f.re = sum_re[FACTOR_W-1:0];
            f.im = sum_im[FACTOR_W-1:0];
            pending_factors = {pending_factors, f};
            sum_re = 0;
            sum_im = 0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_factor();
        factor_t want;
        if (pending_factors.size() == 0) begin
            report_mismatch($sformatf("factor with none pending re=%0d im=%0d",
                                      m_factor_re, m_factor_im));
            return;
        end
        want = pending_factors.pop_front();
        if (m_factor_re !== want.re)
            report_mismatch($sformatf("factor_re got %0d want %0d", m_factor_re, want.re));
        if (m_factor_im !== want.im)
            report_mismatch($sformatf("factor_im got %0d want %0d", m_factor_im, want.im));
        factors_checked++;
    endtask

    // result side: check each beat, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_factor();
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d factors pending",
                     cycle_count, pending_factors.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // all driving tasks start and end right after a rising edge
    task automatic send_element(input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row,
                                input logic signed [CURRENT_W-1:0] cr,
                                input logic signed [CURRENT_W-1:0] ci,
                                input bit last);
        if (!calm && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_grid_col     <= col;
        s_grid_row     <= row;
        s_current_re   <= cr;
        s_current_im   <= ci;
        s_last_element <= last;
        do @(posedge aclk); while (!s_ready);
        rotate_and_accumulate(col, row, cr, ci, last);
        elements_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [STEP_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_STEP_X) step_x = data;
        else if (idx == REG_STEP_Y) step_y = data;
        step_writes++;
    endtask

    // drop valid, let every factor come back, then let the last element retire
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_factors.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [CURRENT_W-1:0] pick_current();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return CURRENT_W'($urandom());
        endcase
    endfunction

    task automatic send_random_sums(input int min_elements);
        int count;
        int len;
        count = 0;
        while (count < min_elements) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                send_element(pick_coord(), pick_coord(), pick_current(), pick_current(),
                             k == len - 1);
            count += len;
        end
    endtask

    task automatic test_reset_steps();
        // steps are zero after reset: every element sees angle zero
        send_element(8'd0, 8'd0, 16'sh7FFF, 16'sd0, 1'b0);
        send_element(8'd255, 8'd255, 16'sh8000, 16'sh8000, 1'b1);
    endtask

    task automatic test_directed_angles();
        wait_drained();
        write_register(REG_STEP_X, 32'h4000_0000);   // quarter turn per column
        write_register(REG_STEP_Y, 32'hFFFF_FFFF);
        write_register(REG_SPARE_LO, 32'h1234_5678);
        write_register(REG_SPARE_HI, 32'hFFFF_FFFF);
        send_element(8'd1, 8'd0, 16'sh7FFF, 16'sd0, 1'b1);
        send_element(8'd2, 8'd0, 16'sh8000, 16'sh7FFF, 1'b1);
        send_element(8'd3, 8'd0, 16'sh7FFF, 16'sh8000, 1'b0);
        send_element(8'd0, 8'd1, -16'sd1, -16'sd1, 1'b0);
        send_element(8'd255, 8'd255, 16'sh8000, 16'sh8000, 1'b1);
        send_element(8'd0, 8'd0, 16'sd0, 16'sd0, 1'b1);
        wait_drained();
        write_register(REG_STEP_X, 32'h2000_0000);   // 45 degrees: largest products
        write_register(REG_STEP_Y, 32'h0000_0000);
        send_element(8'd1, 8'd0, 16'sh8000, 16'sh7FFF, 1'b0);
        send_element(8'd1, 8'd255, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_element(8'd255, 8'd0, 16'sh8000, 16'sh8000, 1'b1);
        wait_drained();
        write_register(REG_STEP_X, 32'hFFFF_FFFF);
        write_register(REG_STEP_Y, 32'h8000_0000);
        send_element(8'd255, 8'd1, 16'sh7FFF, -16'sd1, 1'b0);
        send_element(8'd128, 8'd255, 16'sh8000, 16'sd0, 1'b1);
        send_element(8'd0, 8'd0, 16'sd1, 16'sh8000, 1'b1);
    endtask

    task automatic test_step_sweep();
        logic [STEP_W-1:0] sx, sy;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin sx = '0; sy = '1; end
                1: begin sx = '1; sy = '1; end
                2: begin sx = 32'h8000_0000; sy = 32'h0000_0001; end
                3: begin sx = $urandom_range(0, 1 << 16); sy = $urandom_range(0, 1 << 16); end
                default: begin sx = $urandom(); sy = $urandom(); end
            endcase
            wait_drained();
            if (p != 5) write_register(REG_STEP_X, sx);
            write_register(REG_STEP_Y, sy);
            send_random_sums(30);
        end
    endtask

    task automatic test_streaming_no_idle();
        wait_drained();
        write_register(REG_STEP_X, $urandom());
        write_register(REG_STEP_Y, $urandom());
        calm = 1'b1;
        send_random_sums(80);
        calm = 1'b0;
    endtask

    task automatic test_output_backpressure();
        // receiver stalls while the sender keeps pushing: the block must fill and stall
        calm     = 1'b1;
        hold_req = 1'b1;
        send_random_sums(60);
        calm = 1'b0;
    endtask

    task automatic test_long_sum();
        wait_drained();
        write_register(REG_STEP_X, $urandom());
        write_register(REG_STEP_Y, $urandom());
        for (int k = 0; k < LONG_SUM; k++)
            send_element(COORD_W'($urandom()), COORD_W'($urandom()),
                         CURRENT_W'($urandom()), CURRENT_W'($urandom()),
                         k == LONG_SUM - 1);
    endtask

    initial begin
        build_trig_rom();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_steps();
        test_directed_angles();
        test_step_sweep();
        test_streaming_no_idle();
        test_output_backpressure();
        test_long_sum();
        wait_drained();
        $display("run covered %0d element beats, %0d array factors, %0d register writes",
                 elements_sent, factors_checked, step_writes);
        $display("incl. quadrant angles, spare indexes, a %0d-cycle output stall, a %0d-element sum",
                 HOLD_CYCLES, LONG_SUM);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
